/* rtl/ortq_pkg.sv */
package ortq_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int ID_COUNT_DEF  = 64;
    localparam int TIME_BITS_DEF = 48;

    localparam int KIND_W   = 2;
    localparam int ID_IN_W  = 6;
    localparam int RES_W    = 2;
    localparam int STAT_W   = 3;
    localparam int TCMD_W   = 2;
    localparam int ID_TAB_N = 1 << ID_IN_W;

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // result kinds
    localparam logic [RES_W-1:0] RES_ACK    = 2'd0;
    localparam logic [RES_W-1:0] RES_FIRED  = 2'd1;
    localparam logic [RES_W-1:0] RES_REJECT = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK            = 3'd0;
    localparam logic [STAT_W-1:0] STAT_PAST          = 3'd1;
    localparam logic [STAT_W-1:0] STAT_ID_ACTIVE     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_TIME_DECREASE = 3'd3;
    localparam logic [STAT_W-1:0] STAT_REMOVE_SORTED = 3'd4;
    localparam logic [STAT_W-1:0] STAT_EMPTY         = 3'd5;
    localparam logic [STAT_W-1:0] STAT_FULL          = 3'd6;

    // hardware timer commands
    localparam logic [TCMD_W-1:0] TCMD_LEAVE      = 2'd0;
    localparam logic [TCMD_W-1:0] TCMD_CANCEL     = 2'd1;
    localparam logic [TCMD_W-1:0] TCMD_ARM        = 2'd2;
    localparam logic [TCMD_W-1:0] TCMD_CANCEL_ARM = 2'd3;

    typedef enum logic [1:0] {
        COP_HOLD,
        COP_INSERT,
        COP_SHIFT,
        COP_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     left_le;
        logic     shift;
    } cell_ctl_t;

    typedef struct packed {
        logic le;
        logic match;
    } cell_flags_t;

endpackage

/* rtl/ortq_cell.sv */
module ortq_cell #(
    parameter int TIME_BITS = ortq_pkg::TIME_BITS_DEF,
    parameter int ID_W      = ortq_pkg::ID_IN_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ortq_pkg::cell_ctl_t   ctl,
    input  logic [TIME_BITS-1:0]  new_time,
    input  logic [ID_W-1:0]       new_id,
    input  logic                  left_valid,
    input  logic [TIME_BITS-1:0]  left_time,
    input  logic [ID_W-1:0]       left_id,
    input  logic                  right_valid,
    input  logic [TIME_BITS-1:0]  right_time,
    input  logic [ID_W-1:0]       right_id,
    output logic                  slot_valid,
    output logic [TIME_BITS-1:0]  slot_time,
    output logic [ID_W-1:0]       slot_id,
    output ortq_pkg::cell_flags_t flags
);

    logic                 valid_reg, valid_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [ID_W-1:0]      id_reg, id_next;

    assign flags.le    = valid_reg && (time_reg <= new_time);
    assign flags.match = valid_reg && (id_reg == new_id);

    always_comb begin
        valid_next = valid_reg;
        time_next  = time_reg;
        id_next    = id_reg;
        unique case (ctl.op)
            ortq_pkg::COP_HOLD: begin
            end
            ortq_pkg::COP_INSERT: begin
                // entries at or below the new time stay; the first later one
                // takes the new entry, the rest move one place right
                if (!flags.le) begin
                    if (ctl.left_le) begin
                        valid_next = 1'b1;
                        time_next  = new_time;
                        id_next    = new_id;
                    end else begin
                        valid_next = left_valid;
                        time_next  = left_time;
                        id_next    = left_id;
                    end
                end
            end
            ortq_pkg::COP_SHIFT: begin
                if (ctl.shift) begin
                    valid_next = right_valid;
                    time_next  = right_time;
                    id_next    = right_id;
                end
            end
            ortq_pkg::COP_CLEAR: begin
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        time_reg <= time_next;
        id_reg   <= id_next;
    end

    assign slot_valid = valid_reg;
    assign slot_time  = time_reg;
    assign slot_id    = id_reg;

endmodule

/* rtl/ordered_timer_queue_unit.sv */
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// config   | in        | cfg_wr_en          | cfg_wr_data (sorted_mode)
// request  | in        | s_valid / s_ready  | s_kind, s_timer_id, s_expiry_time, s_now_time
// result   | out       | m_valid / m_ready  | m_result_kind, m_status, m_fired_id,
//          |           |                    | m_timer_cmd, m_arm_delay, m_queue_count, m_last
//
// An item is first registered; then the cell row compares against it in parallel,
// shifts, and loads the result register.
// An expire that fires n timers pops the row once per fired result.
// A waiting result holds the execute step; one request can still be taken in behind it,
// then s_ready stays low until the result transfers.
// Reset empties the cell row at once through per-cell valid bits; no clearing pass.
module ordered_timer_queue_unit #(
    parameter int DEPTH     = ortq_pkg::DEPTH_DEF,
    parameter int ID_COUNT  = ortq_pkg::ID_COUNT_DEF,
    parameter int TIME_BITS = ortq_pkg::TIME_BITS_DEF,
    localparam int CNT_W    = $clog2(DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ortq_pkg::KIND_W-1:0]   s_kind,
    input  logic [ortq_pkg::ID_IN_W-1:0]  s_timer_id,
    input  logic [TIME_BITS-1:0]          s_expiry_time,
    input  logic [TIME_BITS-1:0]          s_now_time,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ortq_pkg::RES_W-1:0]    m_result_kind,
    output logic [ortq_pkg::STAT_W-1:0]   m_status,
    output logic [ortq_pkg::ID_IN_W-1:0]  m_fired_id,
    output logic [ortq_pkg::TCMD_W-1:0]   m_timer_cmd,
    output logic [TIME_BITS-1:0]          m_arm_delay,
    output logic [CNT_W-1:0]              m_queue_count,
    output logic                          m_last
);

    localparam int ID_W = (ID_COUNT >= ortq_pkg::ID_TAB_N) ? ortq_pkg::ID_IN_W
                                                           : $clog2(ID_COUNT);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;

    logic [ortq_pkg::KIND_W-1:0] op_kind_reg;
    logic [ID_W-1:0]             op_id_reg;
    logic [TIME_BITS-1:0]        op_exp_reg;
    logic [TIME_BITS-1:0]        op_now_reg;
    logic [TIME_BITS-1:0]        cur_reg;
    logic                        sorted_reg;
    logic [TIME_BITS-1:0]        latest_reg, latest_next;
    logic [CNT_W-1:0]            count_reg, count_next;

    logic                         m_valid_reg;
    logic [ortq_pkg::RES_W-1:0]   res_kind_reg, res_kind_next;
    logic [ortq_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [ortq_pkg::ID_IN_W-1:0] fired_reg, fired_next;
    logic [ortq_pkg::TCMD_W-1:0]  tcmd_reg, tcmd_next;
    logic [TIME_BITS-1:0]         delay_reg, delay_next;
    logic                         last_reg, last_next;
    logic [CNT_W-1:0]             qcount_reg;

    logic                         emit;
    logic                         out_free;
    ortq_pkg::cell_op_t           cell_op;
    logic [DEPTH-1:0]             shift_mask;

    // timer id modulo ID_COUNT, worked out at elaboration
    logic [ID_W-1:0] id_mod_tab [ortq_pkg::ID_TAB_N];
    for (genvar k = 0; k < ortq_pkg::ID_TAB_N; k++) begin : g_idtab
        assign id_mod_tab[k] = ID_W'(k % ID_COUNT);
    end

    // cell row
    logic                    cell_valid [DEPTH];
    logic [TIME_BITS-1:0]    cell_time  [DEPTH];
    logic [ID_W-1:0]         cell_id    [DEPTH];
    ortq_pkg::cell_flags_t   cell_flags [DEPTH];
    ortq_pkg::cell_ctl_t     cell_ctl   [DEPTH];
    logic [DEPTH-1:0]        le_vec;
    logic [DEPTH-1:0]        match_vec;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                 lv, rv;
        logic [TIME_BITS-1:0] lt, rt;
        logic [ID_W-1:0]      li, ri;

        if (i == 0) begin : g_left_end
            assign lv = 1'b0;
            assign lt = '0;
            assign li = '0;
            assign cell_ctl[i].left_le = 1'b1;
        end else begin : g_left
            assign lv = cell_valid[i-1];
            assign lt = cell_time[i-1];
            assign li = cell_id[i-1];
            assign cell_ctl[i].left_le = le_vec[i-1];
        end

        if (i == DEPTH - 1) begin : g_right_end
            assign rv = 1'b0;
            assign rt = '0;
            assign ri = '0;
        end else begin : g_right
            assign rv = cell_valid[i+1];
            assign rt = cell_time[i+1];
            assign ri = cell_id[i+1];
        end

        assign cell_ctl[i].op    = cell_op;
        assign cell_ctl[i].shift = shift_mask[i];
        assign le_vec[i]         = cell_flags[i].le;
        assign match_vec[i]      = cell_flags[i].match;

        ortq_cell #(
            .TIME_BITS (TIME_BITS),
            .ID_W      (ID_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (cell_ctl[i]),
            .new_time    (op_exp_reg),
            .new_id      (op_id_reg),
            .left_valid  (lv),
            .left_time   (lt),
            .left_id     (li),
            .right_valid (rv),
            .right_time  (rt),
            .right_id    (ri),
            .slot_valid  (cell_valid[i]),
            .slot_time   (cell_time[i]),
            .slot_id     (cell_id[i]),
            .flags       (cell_flags[i])
        );
    end

    // ids in the row are unique, so the match vector is one-hot or zero;
    // the cells at and above the match take their right neighbor
    logic [DEPTH-1:0] remove_mask;
    logic             id_hit;
    assign remove_mask = ~(match_vec - DEPTH'(1));
    assign id_hit      = |match_vec;

    // shared saturating subtract: new entry or next head minus now
    logic [TIME_BITS-1:0] sub_a;
    logic [TIME_BITS:0]   sub_diff;
    logic                 sub_borrow;
    logic [TIME_BITS-1:0] sat_delay;
    assign sub_a      = (op_kind_reg == ortq_pkg::KIND_INSERT) ? op_exp_reg : cell_time[1];
    assign sub_diff   = {1'b0, sub_a} - {1'b0, op_now_reg};
    assign sub_borrow = sub_diff[TIME_BITS];
    assign sat_delay  = sub_borrow ? '0 : sub_diff[TIME_BITS-1:0];

    logic exp_lt_head, exp_lt_latest, is_full, next_same;
    assign exp_lt_head   = op_exp_reg < cell_time[0];
    assign exp_lt_latest = op_exp_reg < latest_reg;
    assign is_full       = count_reg == CNT_W'(DEPTH);
    assign next_same     = cell_valid[1] && (cell_time[1] == cur_reg);

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        emit          = 1'b0;
        cell_op       = ortq_pkg::COP_HOLD;
        shift_mask    = '0;
        count_next    = count_reg;
        latest_next   = latest_reg;
        res_kind_next = ortq_pkg::RES_ACK;
        status_next   = ortq_pkg::STAT_OK;
        fired_next    = '0;
        tcmd_next     = ortq_pkg::TCMD_LEAVE;
        delay_next    = '0;
        last_next     = 1'b1;

        if (state_reg == ST_EXEC && out_free) begin
            emit       = 1'b1;
            state_next = ST_IDLE;
            unique case (op_kind_reg)
                ortq_pkg::KIND_INSERT: begin
                    if (id_hit) begin
                        res_kind_next = ortq_pkg::RES_REJECT;
                        status_next   = ortq_pkg::STAT_ID_ACTIVE;
                    end else if (is_full) begin
                        res_kind_next = ortq_pkg::RES_REJECT;
                        status_next   = ortq_pkg::STAT_FULL;
                    end else if (sorted_reg && exp_lt_latest) begin
                        res_kind_next = ortq_pkg::RES_REJECT;
                        status_next   = ortq_pkg::STAT_TIME_DECREASE;
                    end else begin
                        cell_op     = ortq_pkg::COP_INSERT;
                        count_next  = count_reg + CNT_W'(1);
                        latest_next = exp_lt_latest ? latest_reg : op_exp_reg;
                        status_next = sub_borrow ? ortq_pkg::STAT_PAST : ortq_pkg::STAT_OK;
                        if (count_reg == '0) begin
                            tcmd_next  = ortq_pkg::TCMD_ARM;
                            delay_next = sat_delay;
                        end else if (exp_lt_head) begin
                            tcmd_next  = ortq_pkg::TCMD_CANCEL_ARM;
                            delay_next = sat_delay;
                        end
                    end
                end
                ortq_pkg::KIND_REMOVE: begin
                    if (sorted_reg) begin
                        res_kind_next = ortq_pkg::RES_REJECT;
                        status_next   = ortq_pkg::STAT_REMOVE_SORTED;
                    end else if (id_hit) begin
                        cell_op    = ortq_pkg::COP_SHIFT;
                        shift_mask = remove_mask;
                        count_next = count_reg - CNT_W'(1);
                        if (match_vec[0]) begin
                            if (count_reg == CNT_W'(1)) begin
                                tcmd_next = ortq_pkg::TCMD_CANCEL;
                            end else begin
                                tcmd_next  = ortq_pkg::TCMD_CANCEL_ARM;
                                delay_next = sat_delay;
                            end
                        end
                    end
                end
                ortq_pkg::KIND_EXPIRE: begin
                    if (count_reg == '0) begin
                        res_kind_next = ortq_pkg::RES_REJECT;
                        status_next   = ortq_pkg::STAT_EMPTY;
                    end else begin
                        // pop the head; keep going while the next one shares its time
                        cell_op       = ortq_pkg::COP_SHIFT;
                        shift_mask    = '1;
                        count_next    = count_reg - CNT_W'(1);
                        res_kind_next = ortq_pkg::RES_FIRED;
                        fired_next    = ortq_pkg::ID_IN_W'(cell_id[0]);
                        last_next     = !next_same;
                        if (next_same) begin
                            state_next = ST_EXEC;
                        end else if (cell_valid[1]) begin
                            tcmd_next  = ortq_pkg::TCMD_ARM;
                            delay_next = sat_delay;
                        end
                    end
                end
                ortq_pkg::KIND_CLEAR: begin
                    cell_op    = ortq_pkg::COP_CLEAR;
                    count_next = '0;
                    if (count_reg != '0) begin
                        tcmd_next = ortq_pkg::TCMD_CANCEL;
                    end
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            latest_reg  <= '0;
            sorted_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            latest_reg <= latest_next;
            if (cfg_wr_en) begin
                sorted_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                state_reg <= ST_EXEC;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        if (s_valid && s_ready) begin
            op_kind_reg <= s_kind;
            op_id_reg   <= id_mod_tab[s_timer_id];
            op_exp_reg  <= s_expiry_time;
            op_now_reg  <= s_now_time;
            cur_reg     <= cell_time[0];
        end

        if (emit) begin
            res_kind_reg <= res_kind_next;
            status_reg   <= status_next;
            fired_reg    <= fired_next;
            tcmd_reg     <= tcmd_next;
            delay_reg    <= delay_next;
            last_reg     <= last_next;
            qcount_reg   <= count_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = res_kind_reg;
    assign m_status      = status_reg;
    assign m_fired_id    = fired_reg;
    assign m_timer_cmd   = tcmd_reg;
    assign m_arm_delay   = delay_reg;
    assign m_queue_count = qcount_reg;
    assign m_last        = last_reg;

endmodule
